>>> sv/lrcs_pkg.sv
// Package for the loudspeaker resonance and soft-clip block.
// Holds register indexes, reset values, widths, the controller state type
// and the command and status records shared by the controller and the datapath.
`default_nettype none

package lrcs_pkg;

  localparam int NUM_CHANNELS_DEF = 8;
  localparam int SAMPLE_BITS_DEF  = 24;

  localparam int CHAN_W     = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  localparam int COEF_W     = 18;
  localparam int SCALE_W    = 24;
  localparam int GAIN_W     = 23;
  localparam int WET_W      = 17;

  localparam int RND_SHIFT  = 16;
  localparam int ROUND_HALF = 32768;

  localparam logic [WET_W-1:0] WET_UNITY = 17'd65536;

  localparam logic [CFG_IDX_W-1:0] REG_COEF_IN    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_FB1   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_FB2   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CLIP_SCALE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_GAIN   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_WET_MIX    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_BYPASS_ON  = 3'd6;

  localparam logic signed [COEF_W-1:0] COEF_IN_RST  = 18'sd4508;
  localparam logic signed [COEF_W-1:0] COEF_FB1_RST = 18'sd103560;
  localparam logic signed [COEF_W-1:0] COEF_FB2_RST = -18'sd41943;
  localparam logic [SCALE_W-1:0]       CLIP_SCALE_RST = 24'd32768;
  localparam logic [GAIN_W-1:0]        OUT_GAIN_RST   = 23'd65536;
  localparam logic [WET_W-1:0]         WET_MIX_RST    = 17'd65536;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_FMUL,
    ST_FSUM,
    ST_FSAT,
    ST_CPREP,
    ST_DINIT,
    ST_DIV,
    ST_CFIN,
    ST_GMUL,
    ST_GRND,
    ST_MMUL,
    ST_MSUM,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic load_in;
    logic mem_rd;
    logic f_mul;
    logic f_sum;
    logic f_sat;
    logic c_prep;
    logic d_init;
    logic d_step;
    logic c_fin;
    logic g_mul;
    logic mem_wr;
    logic g_rnd;
    logic m_mul;
    logic m_sum;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic bypass;
    logic out_free;
  } dp_stat_t;

endpackage

`default_nettype wire

>>> sv/loudspeaker_resonance_clip_sim_unit.sv
// Top level of the loudspeaker resonance and soft-clip block.
// Instantiates lrcs_ctrl and lrcs_dp; depends on lrcs_pkg.
//
//   Channel  Direction  Beat carries
//   s_axis   in         tuser: chan_index; tdata: sample_in
//   m_axis   out        tuser: chan_out;   tdata: sample_out
//   cfg      in         cfg_index: register number; cfg_data: value
//
// A processed sample steps through the filter, the bit-serial clipper divider,
// gain and mix on its way to the output register. A bypassed or out-of-range
// sample skips these steps. The next beat is taken only once the current
// sample has gone to the output register.
// Reset is synchronous; all channel state reads as zero after reset at once.
// A new beat is accepted while a finished result waits on m_axis; a stalled
// output holds only the final step of the following sample.
`default_nettype none

module loudspeaker_resonance_clip_sim_unit #(
  parameter int NUM_CHANNELS = lrcs_pkg::NUM_CHANNELS_DEF,
  parameter int SAMPLE_BITS  = lrcs_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 s_axis_tvalid,
  output logic                                      s_axis_tready,
  // sample_in in the low SAMPLE_BITS bits.
  input  wire logic [((SAMPLE_BITS+7)/8)*8-1:0]     s_axis_tdata,
  // chan_index.
  input  wire logic [lrcs_pkg::CHAN_W-1:0]          s_axis_tuser,
  output logic                                      m_axis_tvalid,
  input  wire logic                                 m_axis_tready,
  // sample_out in the low SAMPLE_BITS bits, zeros above.
  output logic [((SAMPLE_BITS+7)/8)*8-1:0]          m_axis_tdata,
  // chan_out.
  output logic [lrcs_pkg::CHAN_W-1:0]               m_axis_tuser,
  input  wire logic                                 cfg_valid,
  output logic                                      cfg_ready,
  input  wire logic [lrcs_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [lrcs_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int TDW = ((SAMPLE_BITS + 7) / 8) * 8;

  lrcs_pkg::dp_cmd_t  cmd;
  lrcs_pkg::dp_stat_t stat;
  logic [SAMPLE_BITS-1:0] out_sample;

  assign cfg_ready = 1'b1;

  lrcs_ctrl #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .cmd      (cmd),
    .stat     (stat)
  );

  lrcs_dp #(
    .NUM_CHANNELS(NUM_CHANNELS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_chan    (s_axis_tuser),
    .in_sample  (s_axis_tdata[SAMPLE_BITS-1:0]),
    .out_ready  (m_axis_tready),
    .out_valid  (m_axis_tvalid),
    .out_chan   (m_axis_tuser),
    .out_sample (out_sample),
    .cmd        (cmd),
    .stat       (stat)
  );

  assign m_axis_tdata = TDW'(out_sample);

endmodule

`default_nettype wire

>>> sv/lrcs_ctrl.sv
// Controller of the loudspeaker resonance and soft-clip block.
// Steps one sample through the datapath and counts the divider iterations.
// Depends on lrcs_pkg.
`default_nettype none

module lrcs_ctrl #(
  parameter int SAMPLE_BITS = lrcs_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  output lrcs_pkg::dp_cmd_t      cmd,
  input  wire lrcs_pkg::dp_stat_t stat
);

  localparam int CNT_W = $clog2(SAMPLE_BITS);

  lrcs_pkg::state_t state, state_next;
  logic [CNT_W-1:0] cnt, cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lrcs_pkg::ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      lrcs_pkg::ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.load_in = in_valid;
        if (in_valid) begin
          state_next = lrcs_pkg::ST_READ;
        end
      end
      lrcs_pkg::ST_READ: begin
        cmd.mem_rd = !stat.bypass;
        state_next = stat.bypass ? lrcs_pkg::ST_OUT : lrcs_pkg::ST_FMUL;
      end
      lrcs_pkg::ST_FMUL: begin
        cmd.f_mul  = 1'b1;
        state_next = lrcs_pkg::ST_FSUM;
      end
      lrcs_pkg::ST_FSUM: begin
        cmd.f_sum  = 1'b1;
        state_next = lrcs_pkg::ST_FSAT;
      end
      lrcs_pkg::ST_FSAT: begin
        cmd.f_sat  = 1'b1;
        state_next = lrcs_pkg::ST_CPREP;
      end
      lrcs_pkg::ST_CPREP: begin
        cmd.c_prep = 1'b1;
        state_next = lrcs_pkg::ST_DINIT;
      end
      lrcs_pkg::ST_DINIT: begin
        cmd.d_init = 1'b1;
        cnt_next   = '0;
        state_next = lrcs_pkg::ST_DIV;
      end
      lrcs_pkg::ST_DIV: begin
        cmd.d_step = 1'b1;
        cnt_next   = cnt + 1'b1;
        if (cnt == CNT_W'(SAMPLE_BITS - 1)) begin
          state_next = lrcs_pkg::ST_CFIN;
        end
      end
      lrcs_pkg::ST_CFIN: begin
        cmd.c_fin  = 1'b1;
        state_next = lrcs_pkg::ST_GMUL;
      end
      lrcs_pkg::ST_GMUL: begin
        cmd.g_mul  = 1'b1;
        cmd.mem_wr = 1'b1;
        state_next = lrcs_pkg::ST_GRND;
      end
      lrcs_pkg::ST_GRND: begin
        cmd.g_rnd  = 1'b1;
        state_next = lrcs_pkg::ST_MMUL;
      end
      lrcs_pkg::ST_MMUL: begin
        cmd.m_mul  = 1'b1;
        state_next = lrcs_pkg::ST_MSUM;
      end
      lrcs_pkg::ST_MSUM: begin
        cmd.m_sum  = 1'b1;
        state_next = lrcs_pkg::ST_OUT;
      end
      lrcs_pkg::ST_OUT: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = lrcs_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = lrcs_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> sv/lrcs_dp.sv
// Datapath of the loudspeaker resonance and soft-clip block: configuration
// registers, per-channel state memory, filter, bit-serial clipper divider,
// gain and wet/dry mix, and the output register. Depends on lrcs_pkg.
`default_nettype none

module lrcs_dp #(
  parameter int NUM_CHANNELS = lrcs_pkg::NUM_CHANNELS_DEF,
  parameter int SAMPLE_BITS  = lrcs_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_valid,
  input  wire logic [lrcs_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [lrcs_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  wire logic [lrcs_pkg::CHAN_W-1:0]         in_chan,
  input  wire logic [SAMPLE_BITS-1:0]              in_sample,
  input  wire logic                                out_ready,
  output logic                                     out_valid,
  output logic [lrcs_pkg::CHAN_W-1:0]              out_chan,
  output logic [SAMPLE_BITS-1:0]                   out_sample,
  input  wire lrcs_pkg::dp_cmd_t                   cmd,
  output lrcs_pkg::dp_stat_t                       stat
);

  localparam int SB   = SAMPLE_BITS;
  localparam int FRAC = SB - 1;
  localparam int UP   = (FRAC >= 16) ? FRAC - 16 : 0;
  localparam int DN   = (FRAC < 16) ? 16 - FRAC : 0;
  localparam int DW   = 25 + UP;
  localparam int PW   = 2 * SB + DN;
  localparam int AW   = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int CW   = lrcs_pkg::CHAN_W;

  localparam logic [SB-1:0] SMAX = {1'b0, {(SB-1){1'b1}}};
  localparam logic [SB-1:0] SMIN = {1'b1, {(SB-1){1'b0}}};

  // Configuration registers.
  logic signed [lrcs_pkg::COEF_W-1:0] coef_in, coef_fb1, coef_fb2;
  logic [lrcs_pkg::SCALE_W-1:0]       clip_scale;
  logic [lrcs_pkg::GAIN_W-1:0]        out_gain;
  logic [lrcs_pkg::WET_W-1:0]         wet_mix;
  logic                               bypass_on;

  always_ff @(posedge clk) begin
    if (rst) begin
      coef_in    <= lrcs_pkg::COEF_IN_RST;
      coef_fb1   <= lrcs_pkg::COEF_FB1_RST;
      coef_fb2   <= lrcs_pkg::COEF_FB2_RST;
      clip_scale <= lrcs_pkg::CLIP_SCALE_RST;
      out_gain   <= lrcs_pkg::OUT_GAIN_RST;
      wet_mix    <= lrcs_pkg::WET_MIX_RST;
      bypass_on  <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        lrcs_pkg::REG_COEF_IN:    coef_in    <= cfg_data[lrcs_pkg::COEF_W-1:0];
        lrcs_pkg::REG_COEF_FB1:   coef_fb1   <= cfg_data[lrcs_pkg::COEF_W-1:0];
        lrcs_pkg::REG_COEF_FB2:   coef_fb2   <= cfg_data[lrcs_pkg::COEF_W-1:0];
        lrcs_pkg::REG_CLIP_SCALE: clip_scale <= cfg_data[lrcs_pkg::SCALE_W-1:0];
        lrcs_pkg::REG_OUT_GAIN:   out_gain   <= cfg_data[lrcs_pkg::GAIN_W-1:0];
        lrcs_pkg::REG_WET_MIX:    wet_mix    <= cfg_data[lrcs_pkg::WET_W-1:0];
        lrcs_pkg::REG_BYPASS_ON:  bypass_on  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Input capture.
  logic [CW-1:0]        chan;
  logic signed [SB-1:0] x;
  logic                 byp;

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      chan <= in_chan;
      x    <= in_sample;
      byp  <= bypass_on || (32'(in_chan) >= 32'(NUM_CHANNELS));
    end
  end

  assign stat.bypass   = byp;
  assign stat.out_free = !out_valid || out_ready;

  // Per-channel state memory: {clip_prev, filt_prev2, filt_prev1}.
  logic [AW+CW-1:0]     chan_ext;
  logic [AW-1:0]        addr;
  logic [3*SB-1:0]      mem [NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0] vld;
  logic [3*SB-1:0]      row;
  logic                 row_vld;
  logic [3*SB-1:0]      row_eff;
  logic signed [SB-1:0] y1_w, y2_w, cp_w;
  logic signed [SB-1:0] y_cur;
  logic signed [SB-1:0] clip;

  assign chan_ext = (AW+CW)'(chan);
  assign addr     = chan_ext[AW-1:0];

  always_ff @(posedge clk) begin
    if (cmd.mem_wr) begin
      mem[addr] <= {clip, y1_w, y_cur};
    end
    if (cmd.mem_rd) begin
      row     <= mem[addr];
      row_vld <= vld[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (cmd.mem_wr) begin
      vld[addr] <= 1'b1;
    end
  end

  assign row_eff = row_vld ? row : '0;
  assign y1_w    = row_eff[SB-1:0];
  assign y2_w    = row_eff[2*SB-1:SB];
  assign cp_w    = row_eff[3*SB-1:2*SB];

  // Resonance filter.
  logic signed [SB+17:0] prod_in, prod_fb1, prod_fb2;
  logic signed [SB+19:0] facc;
  logic signed [SB+3:0]  ys_w;
  logic [4:0]            ys_top;
  logic [SB-1:0]         ysat_w;
  logic [SB-1:0]         mag;
  logic                  neg;

  always_ff @(posedge clk) begin
    if (cmd.f_mul) begin
      prod_in  <= coef_in * x;
      prod_fb1 <= coef_fb1 * y1_w;
      prod_fb2 <= coef_fb2 * y2_w;
    end
    if (cmd.f_sum) begin
      facc <= (SB+20)'(prod_in) + (SB+20)'(prod_fb1) + (SB+20)'(prod_fb2)
            + (SB+20)'(lrcs_pkg::ROUND_HALF);
    end
  end

  assign ys_w   = facc[SB+19:lrcs_pkg::RND_SHIFT];
  assign ys_top = ys_w[SB+3:SB-1];

  always_comb begin
    if ((&ys_top) || !(|ys_top)) begin
      ysat_w = ys_w[SB-1:0];
    end else begin
      ysat_w = ys_top[4] ? SMIN : SMAX;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.f_sat) begin
      y_cur <= ysat_w;
      neg   <= ysat_w[SB-1];
      mag   <= ysat_w[SB-1] ? (~ysat_w + 1'b1) : ysat_w;
    end
  end

  // Soft clipper: the magnitude is m - ceil(m*yd/d), with d = sd + yd.
  logic [SB+DN-1:0] yd_w;
  logic [DW-1:0]    sd_w;
  logic [PW-1:0]    pprod;
  logic [DW-1:0]    dsum;
  logic [DW-1:0]    rem;
  logic [SB-1:0]    quo;
  logic [DW:0]      trial_w;
  logic             ge_w;
  logic [SB-1:0]    r_w;

  assign yd_w = (SB+DN)'(mag) << DN;
  assign sd_w = DW'(clip_scale) << UP;

  always_ff @(posedge clk) begin
    if (cmd.c_prep) begin
      pprod <= PW'(mag) * PW'(yd_w);
      dsum  <= sd_w + DW'(yd_w);
    end
  end

  assign trial_w = {rem, quo[SB-1]};
  assign ge_w    = trial_w >= {1'b0, dsum};

  always_ff @(posedge clk) begin
    if (cmd.d_init) begin
      rem <= DW'(pprod[PW-1:SB]);
      quo <= pprod[SB-1:0];
    end else if (cmd.d_step) begin
      rem <= ge_w ? DW'(trial_w - {1'b0, dsum}) : trial_w[DW-1:0];
      quo <= {quo[SB-2:0], ge_w};
    end
  end

  assign r_w = mag - quo - SB'(rem != '0);

  always_ff @(posedge clk) begin
    if (cmd.c_fin) begin
      if (dsum == '0) begin
        clip <= '0;
      end else begin
        clip <= neg ? (SB'(0) - r_w) : r_w;
      end
    end
  end

  // Output gain on the clipper difference.
  logic signed [SB:0]    diff_w;
  logic signed [SB+24:0] gprod;
  logic signed [SB+24:0] gsum_w;
  logic signed [SB+8:0]  gain_rnd;

  assign diff_w = (SB+1)'(clip) - (SB+1)'(cp_w);
  assign gsum_w = gprod + (SB+25)'(lrcs_pkg::ROUND_HALF);

  always_ff @(posedge clk) begin
    if (cmd.g_mul) begin
      gprod <= diff_w * $signed({1'b0, out_gain});
    end
    if (cmd.g_rnd) begin
      gain_rnd <= gsum_w[SB+24:lrcs_pkg::RND_SHIFT];
    end
  end

  // Wet/dry mix.
  logic [lrcs_pkg::WET_W-1:0] w_w, dw_w;
  logic signed [SB+26:0]      wprod;
  logic signed [SB+17:0]      dprod;
  logic signed [SB+27:0]      macc;
  logic signed [SB+11:0]      mo_w;
  logic [12:0]                mo_top;
  logic [SB-1:0]              msat_w;

  assign w_w  = (wet_mix > lrcs_pkg::WET_UNITY) ? lrcs_pkg::WET_UNITY : wet_mix;
  assign dw_w = lrcs_pkg::WET_UNITY - w_w;

  always_ff @(posedge clk) begin
    if (cmd.m_mul) begin
      wprod <= gain_rnd * $signed({1'b0, w_w});
      dprod <= x * $signed({1'b0, dw_w});
    end
    if (cmd.m_sum) begin
      macc <= (SB+28)'(wprod) + (SB+28)'(dprod) + (SB+28)'(lrcs_pkg::ROUND_HALF);
    end
  end

  assign mo_w   = macc[SB+27:lrcs_pkg::RND_SHIFT];
  assign mo_top = mo_w[SB+11:SB-1];

  always_comb begin
    if ((&mo_top) || !(|mo_top)) begin
      msat_w = mo_w[SB-1:0];
    end else begin
      msat_w = mo_top[12] ? SMIN : SMAX;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_chan   <= chan;
      out_sample <= byp ? x : msat_w;
    end
  end

endmodule

`default_nettype wire

>>> sv/lrcs_checker.sv
// Port-level checker for the loudspeaker resonance and soft-clip block,
// bound to loudspeaker_resonance_clip_sim_unit. Depends on lrcs_pkg.
`default_nettype none

module lrcs_props #(
  parameter int TDATA_W = 24
) (
  input wire logic                        clk,
  input wire logic                        rst,
  input wire logic                        s_axis_tvalid,
  input wire logic                        s_axis_tready,
  input wire logic [lrcs_pkg::CHAN_W-1:0] s_axis_tuser,
  input wire logic                        m_axis_tvalid,
  input wire logic                        m_axis_tready,
  input wire logic [TDATA_W-1:0]          m_axis_tdata,
  input wire logic [lrcs_pkg::CHAN_W-1:0] m_axis_tuser
);

  logic [lrcs_pkg::CHAN_W-1:0] last_chan;

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      last_chan <= s_axis_tuser;
    end
  end

  a_reset_idle: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("Output beat valid straight after reset.");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("Stalled output beat changed.");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("Input taken again while a sample is in progress.");

  a_result_channel: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> !$past(s_axis_tready) && m_axis_tuser == last_chan)
    else $error("Result channel differs from the last accepted beat.");

endmodule

bind loudspeaker_resonance_clip_sim_unit lrcs_props #(
  .TDATA_W(((SAMPLE_BITS + 7) / 8) * 8)
) u_lrcs_props (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

>>> bench/lrcs_checker.sv
`timescale 1ns / 100ps
// Checker for loudspeaker_resonance_clip_sim_unit: follows register writes and sample beats,
// predicts every output sample with its own resonance, clipper and mix arithmetic, and
// compares the result beats in order. Depends on lrcs_pkg.
module lrcs_checker #(
  parameter int SW = lrcs_pkg::SAMPLE_BITS_DEF,
  parameter int DW = ((SW + 7) / 8) * 8
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  input  logic                           s_tready,
  input  logic [DW-1:0]                  s_tdata,
  input  logic [lrcs_pkg::CHAN_W-1:0]    s_tuser,
  input  logic                           m_tvalid,
  input  logic                           m_tready,
  input  logic [DW-1:0]                  m_tdata,
  input  logic [lrcs_pkg::CHAN_W-1:0]    m_tuser,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [lrcs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lrcs_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                             fails,
  output int                             waiting
);

  localparam int NCH = lrcs_pkg::NUM_CHANNELS_DEF;
  localparam int FRAC_UP = SW - 1 - lrcs_pkg::RND_SHIFT;
  localparam longint S_HI = (longint'(1) <<< (SW - 1)) - 1;
  localparam longint S_LO = -S_HI - 1;
  localparam longint UNITY = longint'(lrcs_pkg::WET_UNITY);

  typedef struct packed {
    logic [lrcs_pkg::CHAN_W-1:0] chan;
    logic [SW-1:0]               sample;
  } out_beat_t;

  longint k_in, k_fb1, k_fb2, clip_s, gain, wet;
  logic bypass;
  longint filt_y1 [NCH];
  longint filt_y2 [NCH];
  longint clip_hist [NCH];
  out_beat_t shaped_q [$];
  int mismatches = 0;
  int beats_seen = 0;

  function automatic longint round16(longint v);
    return (v + lrcs_pkg::ROUND_HALF) >>> lrcs_pkg::RND_SHIFT;
  endfunction

  function automatic longint clamp(longint v);
    if (v > S_HI) return S_HI;
    if (v < S_LO) return S_LO;
    return v;
  endfunction

  // The clipped magnitude m*s/(s+m) truncated towards zero, written as m - ceil(m*m/(s+m)).
  function automatic longint soft_limit(longint y, longint s);
    longint m, d, q;
    m = (y < 0) ? -y : y;
    d = (s <<< FRAC_UP) + m;
    if (d == 0) return 0;
    q = (m * m + d - 1) / d;
    return (y < 0) ? q - m : m - q;
  endfunction

  function automatic out_beat_t shape_sample(logic [lrcs_pkg::CHAN_W-1:0] ch,
                                             logic signed [SW-1:0] xin);
    longint x, y, c, g, w, mix;
    out_beat_t r;
    x = xin;
    r.chan = ch;
    r.sample = xin;
    if (bypass || ch >= NCH) return r;
    y = clamp(round16(k_in * x + k_fb1 * filt_y1[ch] + k_fb2 * filt_y2[ch]));
    filt_y2[ch] = filt_y1[ch];
    filt_y1[ch] = y;
    c = soft_limit(y, clip_s);
    g = round16((c - clip_hist[ch]) * gain);
    clip_hist[ch] = c;
    w = (wet > UNITY) ? UNITY : wet;
    mix = clamp(round16(g * w + x * (UNITY - w)));
    r.sample = mix[SW-1:0];
    return r;
  endfunction

  task automatic flag_mismatch(string msg);
    $display("%0t ns: result beat %0d: %s", $time, beats_seen, msg);
    mismatches++;
  endtask

  always @(posedge clk) begin
    out_beat_t want;
    if (rst) begin
      k_in = lrcs_pkg::COEF_IN_RST;
      k_fb1 = lrcs_pkg::COEF_FB1_RST;
      k_fb2 = lrcs_pkg::COEF_FB2_RST;
      clip_s = lrcs_pkg::CLIP_SCALE_RST;
      gain = lrcs_pkg::OUT_GAIN_RST;
      wet = lrcs_pkg::WET_MIX_RST;
      bypass = 1'b0;
      for (int k = 0; k < NCH; k++) begin
        filt_y1[k] = 0;
        filt_y2[k] = 0;
        clip_hist[k] = 0;
      end
      shaped_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          lrcs_pkg::REG_COEF_IN:    k_in = $signed(cfg_data[lrcs_pkg::COEF_W-1:0]);
          lrcs_pkg::REG_COEF_FB1:   k_fb1 = $signed(cfg_data[lrcs_pkg::COEF_W-1:0]);
          lrcs_pkg::REG_COEF_FB2:   k_fb2 = $signed(cfg_data[lrcs_pkg::COEF_W-1:0]);
          lrcs_pkg::REG_CLIP_SCALE: clip_s = cfg_data[lrcs_pkg::SCALE_W-1:0];
          lrcs_pkg::REG_OUT_GAIN:   gain = cfg_data[lrcs_pkg::GAIN_W-1:0];
          lrcs_pkg::REG_WET_MIX:    wet = cfg_data[lrcs_pkg::WET_W-1:0];
          lrcs_pkg::REG_BYPASS_ON:  bypass = cfg_data[0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready)
        shaped_q.push_back(shape_sample(s_tuser, s_tdata[SW-1:0]));
      if (m_tvalid && m_tready) begin
        if (shaped_q.size() == 0) begin
          flag_mismatch($sformatf("unexpected beat, chan_out %0d sample_out %0d",
                                  m_tuser, $signed(m_tdata[SW-1:0])));
        end else begin
          want = shaped_q.pop_front();
          if (m_tuser !== want.chan)
            flag_mismatch($sformatf("chan_out %0d, expected %0d", m_tuser, want.chan));
          if (m_tdata[SW-1:0] !== want.sample)
            flag_mismatch($sformatf("sample_out %0d, expected %0d on channel %0d",
                                    $signed(m_tdata[SW-1:0]), $signed(want.sample),
                                    want.chan));
        end
        beats_seen++;
      end
    end
    fails <= mismatches;
    waiting <= shaped_q.size();
  end

endmodule

>>> bench/tb.sv
`timescale 1ns / 100ps
// Top of the testbench for loudspeaker_resonance_clip_sim_unit: drives register writes and
// sample beats with random gaps and output stalls, and gives the verdict.
// Depends on lrcs_pkg, the block and lrcs_checker.
module tb;

  localparam int SW = lrcs_pkg::SAMPLE_BITS_DEF;
  localparam int DW = ((SW + 7) / 8) * 8;
  localparam logic [lrcs_pkg::CFG_IDX_W-1:0] REG_SPARE = 3'd7;
  localparam int SEGMENTS = 8;
  localparam int SEG_BEATS = 156;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [DW-1:0] s_axis_tdata = '0;
  logic [lrcs_pkg::CHAN_W-1:0] s_axis_tuser = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [DW-1:0] m_axis_tdata;
  logic [lrcs_pkg::CHAN_W-1:0] m_axis_tuser;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [lrcs_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [lrcs_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  int src_idle = 31;
  int dst_idle = 85;
  int fails;
  int waiting;

  always #5 clk = ~clk;

  loudspeaker_resonance_clip_sim_unit dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  lrcs_checker #(.SW(SW), .DW(DW)) u_checker (
    .clk(clk), .rst(rst),
    .s_tvalid(s_axis_tvalid), .s_tready(s_axis_tready),
    .s_tdata(s_axis_tdata), .s_tuser(s_axis_tuser),
    .m_tvalid(m_axis_tvalid), .m_tready(m_axis_tready),
    .m_tdata(m_axis_tdata), .m_tuser(m_axis_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fails(fails), .waiting(waiting)
  );

  always @(posedge clk) m_axis_tready <= ($urandom_range(99) >= dst_idle);

  task automatic send_sample(int ch, logic [DW-1:0] v);
    while ($urandom_range(99) < src_idle) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= ch[lrcs_pkg::CHAN_W-1:0];
    s_axis_tdata <= v;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  task automatic write_reg(logic [lrcs_pkg::CFG_IDX_W-1:0] idx, longint value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value[lrcs_pkg::CFG_DATA_W-1:0];
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (waiting != 0) @(posedge clk);
  endtask

  function automatic logic [DW-1:0] pick_sample();
    logic signed [SW-1:0] v;
    int unsigned sel;
    v = SW'($urandom);
    sel = $urandom_range(7);
    if (sel == 0) return $urandom_range(1) ? 24'h7FFFFF : 24'h800000;
    if (sel < 4) return v;
    return v >>> $urandom_range(4, 20);
  endfunction

  // Even segments get a stable resonance; odd ones take coefficients from the whole range.
  task automatic set_random_tone(int seg);
    longint ru, fb1, fb2, gin;
    ru = $urandom_range(32768, 65400);
    fb2 = -((ru * ru) >>> 16);
    fb1 = $urandom_range(0, 2 * ru - 1);
    gin = $urandom_range(0, 16384);
    if ($urandom_range(1)) fb1 = -fb1;
    if ($urandom_range(1)) gin = -gin;
    if (seg % 2 == 1) begin
      fb1 = $urandom;
      fb2 = $urandom;
      gin = $urandom;
    end
    write_reg(lrcs_pkg::REG_COEF_IN, gin);
    write_reg(lrcs_pkg::REG_COEF_FB1, fb1);
    write_reg(lrcs_pkg::REG_COEF_FB2, fb2);
    case ($urandom_range(3))
      0: write_reg(lrcs_pkg::REG_CLIP_SCALE, $urandom_range(1, 65536));
      1: write_reg(lrcs_pkg::REG_CLIP_SCALE, $urandom);
      2: write_reg(lrcs_pkg::REG_CLIP_SCALE, 24'hFFFFFF);
      default: write_reg(lrcs_pkg::REG_CLIP_SCALE, $urandom_range(1, 255));
    endcase
    case ($urandom_range(3))
      0: write_reg(lrcs_pkg::REG_OUT_GAIN, 65536);
      1: write_reg(lrcs_pkg::REG_OUT_GAIN, $urandom_range(0, 6553600));
      2: write_reg(lrcs_pkg::REG_OUT_GAIN, $urandom_range(0, 262144));
      default: write_reg(lrcs_pkg::REG_OUT_GAIN, $urandom);
    endcase
    case ($urandom_range(3))
      0: write_reg(lrcs_pkg::REG_WET_MIX, 65536);
      1: write_reg(lrcs_pkg::REG_WET_MIX, $urandom_range(0, 65536));
      2: write_reg(lrcs_pkg::REG_WET_MIX, 0);
      default: write_reg(lrcs_pkg::REG_WET_MIX, $urandom);
    endcase
    write_reg(lrcs_pkg::REG_BYPASS_ON, ($urandom & 24'hFFFFFE) | (seg == 4));
    write_reg(REG_SPARE, $urandom);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_sample(0, 24'h7FFFFF);
    send_sample(0, 24'h7FFFFF);
    send_sample(7, 24'h800000);
    send_sample(7, 24'h800000);
    send_sample(3, 24'h000000);
    send_sample(3, 24'hFFFFFF);
    send_sample(5, 24'h000001);
    send_sample(1, 24'h7FFFFF);
    send_sample(1, 24'h800000);
    send_sample(2, 24'h400000);

    // Unstable filter, clip scale of zero, gain and wet beyond their ranges.
    settle();
    write_reg(lrcs_pkg::REG_COEF_IN, 24'h01FFFF);
    write_reg(lrcs_pkg::REG_COEF_FB1, 24'hFE0000);
    write_reg(lrcs_pkg::REG_COEF_FB2, 24'hE1FFFF);
    write_reg(lrcs_pkg::REG_CLIP_SCALE, 24'h000000);
    write_reg(lrcs_pkg::REG_OUT_GAIN, 24'hFFFFFF);
    write_reg(lrcs_pkg::REG_WET_MIX, 24'hFFFFFF);
    write_reg(lrcs_pkg::REG_BYPASS_ON, 24'h000000);
    write_reg(REG_SPARE, 24'hFFFFFF);
    cfg_valid <= 1'b0;
    send_sample(0, 24'h7FFFFF);
    send_sample(0, 24'h800000);
    send_sample(6, 24'h123456);
    send_sample(6, 24'h800000);
    send_sample(4, 24'h7FFFFF);

    // Opposite coefficient extremes with an all-dry mix.
    settle();
    write_reg(lrcs_pkg::REG_COEF_IN, 24'h020000);
    write_reg(lrcs_pkg::REG_COEF_FB1, 24'h01FFFF);
    write_reg(lrcs_pkg::REG_COEF_FB2, 24'h020000);
    write_reg(lrcs_pkg::REG_CLIP_SCALE, 24'hFFFFFF);
    write_reg(lrcs_pkg::REG_OUT_GAIN, 6553600);
    write_reg(lrcs_pkg::REG_WET_MIX, 0);
    cfg_valid <= 1'b0;
    send_sample(2, 24'h7FFFFF);
    send_sample(2, 24'h800000);
    send_sample(7, 24'h000001);

    settle();
    write_reg(lrcs_pkg::REG_BYPASS_ON, 24'h000001);
    write_reg(lrcs_pkg::REG_WET_MIX, 65536);
    write_reg(lrcs_pkg::REG_CLIP_SCALE, 1);
    cfg_valid <= 1'b0;
    send_sample(0, 24'h7FFFFF);
    send_sample(7, 24'h800000);
    send_sample(3, 24'h5A5A5A);

    settle();
    write_reg(lrcs_pkg::REG_BYPASS_ON, 24'hFFFFFE);
    write_reg(lrcs_pkg::REG_WET_MIX, 32768);
    write_reg(lrcs_pkg::REG_OUT_GAIN, 0);
    cfg_valid <= 1'b0;
    send_sample(1, 24'h7FFFFF);
    send_sample(1, 24'h800000);
    send_sample(1, 24'hA5A5A5);

    for (int seg = 0; seg < SEGMENTS; seg++) begin
      if (seg == 3) begin
        src_idle = 85;
        dst_idle = 31;
      end
      if (seg == 6) begin
        src_idle = 0;
        dst_idle = 0;
      end
      settle();
      set_random_tone(seg);
      repeat (SEG_BEATS) send_sample($urandom_range(7), pick_sample());
    end

    settle();
    repeat (64) @(posedge clk);
    if (fails == 0) begin
      $display("PASS loudspeaker_resonance_clip_sim_unit");
    end else begin
      $display("FAIL loudspeaker_resonance_clip_sim_unit");
    end
    $finish;
  end

  initial begin
    #10ms;
    $display("FAIL loudspeaker_resonance_clip_sim_unit");
    $finish;
  end

endmodule

>>> loudspeaker_resonance_clip_sim_unit.f
sv/lrcs_pkg.sv
sv/lrcs_ctrl.sv
sv/lrcs_dp.sv
sv/loudspeaker_resonance_clip_sim_unit.sv
sv/lrcs_checker.sv
bench/lrcs_checker.sv
bench/tb.sv
